>>> hw/rtl/wvm_pkg.sv
package wvm_pkg;

	// Build options
	localparam int MAX_WHEELS = 4;
	localparam int DEF_WHEELS = 4;

	// Field widths
	localparam int SPEED_W    = 16;
	localparam int COEF_W     = 16;
	localparam int LIM_W      = 15;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 48;
	localparam int PROD_W     = 2 * SPEED_W;
	localparam int SUM_W      = PROD_W + 1;
	localparam int ABS_W      = PROD_W;
	localparam int MAG_W      = SPEED_W + 1;
	localparam int NUM_W      = 31;
	localparam int QUO_W      = LIM_W;

	// Q2.13 scaling
	localparam int FRAC_BITS = 13;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL0_COEF = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL1_COEF = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL2_COEF = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL3_COEF = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_INPUT   = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INPUT   = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_OUTPUT  = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_OUTPUT  = 8'd7;

	// Pipeline stage numbers
	localparam int ST_CMD   = 1;
	localparam int ST_PROD  = 2;
	localparam int ST_SUM   = 3;
	localparam int ST_SPEED = 4;
	localparam int ST_MERGE = 5;
	localparam int ST_NUM   = 6;
	localparam int ST_DIV0  = 7;
	localparam int ST_OUT   = ST_DIV0 + QUO_W;
	localparam int STAGES   = ST_OUT;

	typedef logic signed [SPEED_W-1:0] speed_t;
	typedef logic [MAG_W-1:0] mag_t;

	// Stage enables for one mixing lane
	typedef struct packed {
		logic prod;
		logic sum;
		logic speed;
	} mix_en_t;

	// Side data carried along the divider stages
	typedef struct packed {
		logic [MAX_WHEELS-1:0][SPEED_W-1:0] speed;
		logic rescale;
	} wvm_meta_t;

endpackage

>>> hw/rtl/wvm_cmd_if.sv
interface wvm_cmd_if;
	logic valid;
	logic ready;
	logic signed [wvm_pkg::SPEED_W-1:0] vel_x;
	logic signed [wvm_pkg::SPEED_W-1:0] vel_y;
	logic signed [wvm_pkg::SPEED_W-1:0] yaw_rate;

	modport source (output valid, output vel_x, output vel_y, output yaw_rate, input ready);
	modport sink (input valid, input vel_x, input vel_y, input yaw_rate, output ready);
endinterface

>>> hw/rtl/wvm_wheel_if.sv
interface wvm_wheel_if;
	logic valid;
	logic ready;
	logic signed [wvm_pkg::SPEED_W-1:0] wheel0_speed;
	logic signed [wvm_pkg::SPEED_W-1:0] wheel1_speed;
	logic signed [wvm_pkg::SPEED_W-1:0] wheel2_speed;
	logic signed [wvm_pkg::SPEED_W-1:0] wheel3_speed;
	logic was_rescaled;

	modport source (output valid, output wheel0_speed, output wheel1_speed,
		output wheel2_speed, output wheel3_speed, output was_rescaled, input ready);
	modport sink (input valid, input wheel0_speed, input wheel1_speed,
		input wheel2_speed, input wheel3_speed, input was_rescaled, output ready);
endinterface

>>> hw/rtl/wvm_cfg_if.sv
interface wvm_cfg_if;
	logic valid;
	logic ready;
	logic [wvm_pkg::CFG_IDX_W-1:0] index;
	logic [wvm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/wheel_velocity_mixer.sv
// Throughput: one request per cycle while the output is not stalled; the
// fifteen-stage restoring divider per wheel, one quotient bit per stage, sets
// the depth of the pipeline.
// Stalls ripple back stage by stage, so empty stages keep filling.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the
// register defaults: zero coefficients, full-scale limits, no dead bands.
module wheel_velocity_mixer #(
	parameter int WHEELS = wvm_pkg::DEF_WHEELS
) (
	input logic clk,
	input logic arst_n,
	wvm_cmd_if.sink     cmd,
	wvm_wheel_if.source wheel,
	wvm_cfg_if.sink     cfg
);

	localparam int NW = wvm_pkg::MAX_WHEELS;

	// Configuration registers
	logic [wvm_pkg::CFG_DATA_W-1:0] coef_q [NW];
	logic [wvm_pkg::LIM_W-1:0]      max_in_q;
	logic [wvm_pkg::LIM_W-1:0]      min_in_q;
	logic [wvm_pkg::LIM_W-1:0]      max_out_q;
	logic [wvm_pkg::LIM_W-1:0]      min_out_q;

	// Pipeline control
	logic [wvm_pkg::STAGES:1]   valid_q;
	logic [wvm_pkg::STAGES+1:1] rdy;

	// Datapath
	wvm_pkg::speed_t           cmd_s1 [3];
	wvm_pkg::speed_t           speed_s4 [NW];
	wvm_pkg::mag_t             mag_s4 [NW];
	wvm_pkg::speed_t           speed_s5 [NW];
	wvm_pkg::mag_t             mag_s5 [NW];
	wvm_pkg::mag_t             largest_s5;
	logic                      rescale_s5;
	logic [wvm_pkg::NUM_W-1:0] num_s6 [NW];
	wvm_pkg::mag_t             largest_s6;
	wvm_pkg::wvm_meta_t        meta_s6;
	wvm_pkg::wvm_meta_t        meta_dv [wvm_pkg::QUO_W];
	logic [wvm_pkg::QUO_W-1:0] quo [NW];
	wvm_pkg::speed_t           out_s22 [NW];
	logic                      rescaled_s22;

	wvm_pkg::mag_t             largest_next;
	wvm_pkg::mix_en_t          mix_en;

	// Register writes; unknown indexes are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < NW; w++) coef_q[w] <= '0;
			max_in_q  <= '1;
			min_in_q  <= '0;
			max_out_q <= '1;
			min_out_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				wvm_pkg::REG_WHEEL0_COEF: coef_q[0] <= cfg.data;
				wvm_pkg::REG_WHEEL1_COEF: coef_q[1] <= cfg.data;
				wvm_pkg::REG_WHEEL2_COEF: coef_q[2] <= cfg.data;
				wvm_pkg::REG_WHEEL3_COEF: coef_q[3] <= cfg.data;
				wvm_pkg::REG_MAX_INPUT:   max_in_q  <= cfg.data[wvm_pkg::LIM_W-1:0];
				wvm_pkg::REG_MIN_INPUT:   min_in_q  <= cfg.data[wvm_pkg::LIM_W-1:0];
				wvm_pkg::REG_MAX_OUTPUT:  max_out_q <= cfg.data[wvm_pkg::LIM_W-1:0];
				wvm_pkg::REG_MIN_OUTPUT:  min_out_q <= cfg.data[wvm_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// A stage takes new data when it is empty or its content moves on
	assign rdy[wvm_pkg::STAGES+1] = wheel.ready;
	for (genvar k = 1; k <= wvm_pkg::STAGES; k++) begin : g_rdy
		assign rdy[k] = !valid_q[k] || rdy[k+1];
	end
	assign cmd.ready = rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (rdy[1]) valid_q[1] <= cmd.valid;
			for (int k = 2; k <= wvm_pkg::STAGES; k++) begin
				if (rdy[k]) valid_q[k] <= valid_q[k-1];
			end
		end
	end

	// Input guard: magnitude limit, then dead band
	function automatic wvm_pkg::speed_t guard(input wvm_pkg::speed_t v,
		input logic [wvm_pkg::LIM_W-1:0] lim, input logic [wvm_pkg::LIM_W-1:0] dz);
		logic signed [wvm_pkg::MAG_W-1:0] x;
		logic signed [wvm_pkg::MAG_W-1:0] hi;
		logic [wvm_pkg::MAG_W-1:0]        m;
		x  = wvm_pkg::MAG_W'(v);
		hi = $signed({2'b00, lim});
		if (x > hi) x = hi;
		if (x < -hi) x = -hi;
		m = x[wvm_pkg::MAG_W-1] ? $unsigned(-x) : $unsigned(x);
		if (m < {2'b00, dz}) x = '0;
		return x[wvm_pkg::SPEED_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (rdy[wvm_pkg::ST_CMD]) begin
			cmd_s1[0] <= guard(cmd.vel_x, max_in_q, min_in_q);
			cmd_s1[1] <= guard(cmd.vel_y, max_in_q, min_in_q);
			cmd_s1[2] <= guard(cmd.yaw_rate, max_in_q, min_in_q);
		end
	end

	// Mixing and dividing lanes, one per wheel
	assign mix_en = '{prod: rdy[wvm_pkg::ST_PROD], sum: rdy[wvm_pkg::ST_SUM],
		speed: rdy[wvm_pkg::ST_SPEED]};

	for (genvar w = 0; w < NW; w++) begin : g_lane
		if (w < WHEELS) begin : g_on
			wvm_mix_lane u_mix (
				.clk      (clk),
				.en       (mix_en),
				.coef     (coef_q[w]),
				.cmd_x    (cmd_s1[0]),
				.cmd_y    (cmd_s1[1]),
				.cmd_yaw  (cmd_s1[2]),
				.speed_s4 (speed_s4[w]),
				.mag_s4   (mag_s4[w])
			);

			wvm_div_lane u_div (
				.clk (clk),
				.en  (rdy[wvm_pkg::ST_DIV0 +: wvm_pkg::QUO_W]),
				.num (num_s6[w]),
				.den (largest_s6),
				.quo (quo[w])
			);
		end else begin : g_off
			assign speed_s4[w] = '0;
			assign mag_s4[w]   = '0;
			assign quo[w]      = '0;
		end
	end

	// Merge: largest magnitude over the wheels
	always_comb begin
		largest_next = '0;
		for (int w = 0; w < NW; w++) begin
			if (mag_s4[w] > largest_next) largest_next = mag_s4[w];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[wvm_pkg::ST_MERGE]) begin
			speed_s5   <= speed_s4;
			mag_s5     <= mag_s4;
			largest_s5 <= largest_next;
			rescale_s5 <= largest_next > {2'b00, max_out_q};
		end
	end

	// Rescale numerator: m * max_output + largest / 2
	always_ff @(posedge clk) begin
		if (rdy[wvm_pkg::ST_NUM]) begin
			for (int w = 0; w < NW; w++) begin
				num_s6[w] <= wvm_pkg::NUM_W'(
					({15'd0, mag_s5[w]} * {17'd0, max_out_q}) + {16'd0, largest_s5[16:1]});
				meta_s6.speed[w] <= speed_s5[w];
			end
			largest_s6      <= largest_s5;
			meta_s6.rescale <= rescale_s5;
		end
	end

	// Side data follows the divider stages
	always_ff @(posedge clk) begin
		if (rdy[wvm_pkg::ST_DIV0]) meta_dv[0] <= meta_s6;
		for (int k = 1; k < wvm_pkg::QUO_W; k++) begin
			if (rdy[wvm_pkg::ST_DIV0 + k]) meta_dv[k] <= meta_dv[k-1];
		end
	end

	// Output: pick scaled or plain speed, then the output dead band
	always_ff @(posedge clk) begin
		if (rdy[wvm_pkg::ST_OUT]) begin
			for (int w = 0; w < NW; w++) begin
				wvm_pkg::speed_t sp;
				wvm_pkg::mag_t   m;
				sp = meta_dv[wvm_pkg::QUO_W-1].speed[w];
				if (meta_dv[wvm_pkg::QUO_W-1].rescale) begin
					m  = wvm_pkg::MAG_W'(quo[w]);
					sp = sp[wvm_pkg::SPEED_W-1] ? -wvm_pkg::SPEED_W'(quo[w])
						: wvm_pkg::SPEED_W'(quo[w]);
				end else begin
					m = sp[wvm_pkg::SPEED_W-1] ? wvm_pkg::MAG_W'(-wvm_pkg::MAG_W'(sp))
						: wvm_pkg::MAG_W'(sp);
				end
				if (w >= WHEELS || m < {2'b00, min_out_q}) sp = '0;
				out_s22[w] <= sp;
			end
			rescaled_s22 <= meta_dv[wvm_pkg::QUO_W-1].rescale;
		end
	end

	assign wheel.valid        = valid_q[wvm_pkg::STAGES];
	assign wheel.wheel0_speed = out_s22[0];
	assign wheel.wheel1_speed = out_s22[1];
	assign wheel.wheel2_speed = out_s22[2];
	assign wheel.wheel3_speed = out_s22[3];
	assign wheel.was_rescaled = rescaled_s22;

	// An open output lets the whole pipeline move
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		wheel.ready |-> cmd.ready)
		else $error("input stalled while output is open");

	// A stalled merge stage keeps its item and its maximum
	a_merge_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q[wvm_pkg::ST_MERGE] && !rdy[wvm_pkg::ST_MERGE+1]
		|=> valid_q[wvm_pkg::ST_MERGE] && $stable(largest_s5))
		else $error("merge stage lost a stalled item");

	// Rescaling needs a nonzero divisor
	a_rescale_den: assert property (@(posedge clk) disable iff (!arst_n)
		rescale_s5 |-> largest_s5 != '0)
		else $error("rescale with zero largest magnitude");

	// Missing wheel stays at zero
	a_spare_wheel: assert property (@(posedge clk) disable iff (!arst_n)
		wheel.valid |-> (WHEELS > 3) || (wheel.wheel3_speed == '0))
		else $error("unused wheel driven");

endmodule

>>> hw/rtl/wvm_mix_lane.sv
module wvm_mix_lane (
	input  logic                                clk,
	input  wvm_pkg::mix_en_t                    en,
	input  logic [wvm_pkg::CFG_DATA_W-1:0]      coef,
	input  wvm_pkg::speed_t                     cmd_x,
	input  wvm_pkg::speed_t                     cmd_y,
	input  wvm_pkg::speed_t                     cmd_yaw,
	output wvm_pkg::speed_t                     speed_s4,
	output wvm_pkg::mag_t                       mag_s4
);

	logic signed [wvm_pkg::PROD_W-1:0] prod_s2 [3];
	logic signed [wvm_pkg::SUM_W-1:0]  sum_s3;

	logic [wvm_pkg::ABS_W-1:0] abs_sum;
	logic [wvm_pkg::ABS_W-1:0] rnd;
	logic [wvm_pkg::ABS_W-1:0] lim;
	wvm_pkg::mag_t             mag_next;
	logic                      neg;

	// One product per command component
	always_ff @(posedge clk) begin
		if (en.prod) begin
			prod_s2[0] <= $signed(coef[15:0]) * cmd_x;
			prod_s2[1] <= $signed(coef[31:16]) * cmd_y;
			prod_s2[2] <= $signed(coef[47:32]) * cmd_yaw;
		end
	end

	// Exact dot product
	always_ff @(posedge clk) begin
		if (en.sum) begin
			sum_s3 <= wvm_pkg::SUM_W'(prod_s2[0]) + wvm_pkg::SUM_W'(prod_s2[1])
				+ wvm_pkg::SUM_W'(prod_s2[2]);
		end
	end

	// Back from Q2.13, round half away from zero, saturate
	always_comb begin
		neg     = sum_s3[wvm_pkg::SUM_W-1];
		abs_sum = neg ? wvm_pkg::ABS_W'(-sum_s3) : wvm_pkg::ABS_W'(sum_s3);
		rnd     = (abs_sum + (wvm_pkg::ABS_W'(1) << (wvm_pkg::FRAC_BITS - 1)))
			>> wvm_pkg::FRAC_BITS;
		lim     = neg ? wvm_pkg::ABS_W'(32768) : wvm_pkg::ABS_W'(32767);
		mag_next = (rnd > lim) ? wvm_pkg::MAG_W'(lim) : wvm_pkg::MAG_W'(rnd);
	end

	always_ff @(posedge clk) begin
		if (en.speed) begin
			mag_s4   <= mag_next;
			speed_s4 <= neg ? wvm_pkg::SPEED_W'(-mag_next) : wvm_pkg::SPEED_W'(mag_next);
		end
	end

endmodule

>>> hw/rtl/wvm_div_lane.sv
module wvm_div_lane (
	input  logic                           clk,
	input  logic [wvm_pkg::QUO_W-1:0]      en,
	input  logic [wvm_pkg::NUM_W-1:0]      num,
	input  wvm_pkg::mag_t                  den,
	output logic [wvm_pkg::QUO_W-1:0]      quo
);

	// Restoring division, one quotient bit per stage, high bit first.
	// The numerator is known to be below den << QUO_W.
	logic [wvm_pkg::NUM_W-1:0] rem_s [wvm_pkg::QUO_W];
	wvm_pkg::mag_t             den_s [wvm_pkg::QUO_W];
	logic [wvm_pkg::QUO_W-1:0] quo_s [wvm_pkg::QUO_W];

	for (genvar k = 0; k < wvm_pkg::QUO_W; k++) begin : g_step
		localparam int B = wvm_pkg::QUO_W - 1 - k;

		logic [wvm_pkg::NUM_W-1:0] rem_in;
		wvm_pkg::mag_t             den_in;
		logic [wvm_pkg::QUO_W-1:0] quo_in;
		logic [wvm_pkg::NUM_W-1:0] trial;
		logic                      fits;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign trial = wvm_pkg::NUM_W'(den_in) << B;
		assign fits  = rem_in >= trial;

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= fits ? rem_in - trial : rem_in;
				den_s[k] <= den_in;
				quo_s[k] <= quo_in | (wvm_pkg::QUO_W'(fits) << B);
			end
		end
	end

	assign quo = quo_s[wvm_pkg::QUO_W-1];

endmodule

>>> tb/wheel_velocity_mixer_tb.sv
`timescale 1ns / 100ps

module wheel_velocity_mixer_tb;
	import wvm_pkg::*;

	localparam int WHEELS        = DEF_WHEELS;
	localparam int CLK_PERIOD    = 10;
	localparam int TIMEOUT_NS    = 4_000_000;
	localparam int RANDOM_BLOCKS = 8;
	localparam int BLOCK_ITEMS   = 244;
	localparam int TABLE_ROWS    = 23;

	// Index with no register behind it; writes must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hC3;

	// Register setups used by the directed table
	typedef enum logic [2:0] {
		SET_RESET,
		SET_UNIT,
		SET_MECANUM,
		SET_ZERO_MAX_OUT,
		SET_CROSSED_IN
	} setting_e;

	// Speeds of one result, as compared against the block
	typedef struct packed {
		logic [MAX_WHEELS-1:0][SPEED_W-1:0] speed;
		logic rescaled;
	} wheel_set_t;

	// One directed request; typed rows carry their expected wheels
	typedef struct packed {
		setting_e setting;
		speed_t vx;
		speed_t vy;
		speed_t vyaw;
		logic typed;
		speed_t w0;
		speed_t w1;
		speed_t w2;
		speed_t w3;
		logic rescaled;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	wvm_cmd_if   cmd_bus();
	wvm_wheel_if wheel_bus();
	wvm_cfg_if   cfg_bus();

	wheel_velocity_mixer #(.WHEELS(WHEELS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.wheel(wheel_bus),
		.cfg(cfg_bus)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shadow of the register file, updated as writes are accepted
	logic [CFG_DATA_W-1:0] coef_row [MAX_WHEELS];
	logic [LIM_W-1:0] in_limit;
	logic [LIM_W-1:0] in_band;
	logic [LIM_W-1:0] out_limit;
	logic [LIM_W-1:0] out_band;

	wheel_set_t pending_wheels [$];
	int bad_results = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// Directed requests: extremes, rounding ties, clamps, dead bands, rescaling
	stim_row_t stim_table [TABLE_ROWS] = '{
		// all coefficients zero after reset
		'{SET_RESET, 0, 0, 0, 1'b1, 0, 0, 0, 0, 1'b0},
		'{SET_RESET, 32767, -32768, 12345, 1'b1, 0, 0, 0, 0, 1'b0},
		'{SET_RESET, -32768, 32767, -1, 1'b1, 0, 0, 0, 0, 1'b0},
		// one axis per wheel, wheel 3 mixes -x and y/2
		'{SET_UNIT, 32767, 0, 0, 1'b1, 32767, 0, 0, -32767, 1'b0},
		'{SET_UNIT, 0, -32768, 0, 1'b1, 0, -32767, 0, -16384, 1'b0},
		'{SET_UNIT, 0, 0, -32768, 1'b1, 0, 0, -32767, 0, 1'b0},
		'{SET_UNIT, -32768, 32767, 0, 1'b0, 0, 0, 0, 0, 1'b0},
		'{SET_UNIT, 1, 1, 0, 1'b0, 0, 0, 0, 0, 1'b0},
		'{SET_UNIT, -1, -1, 0, 1'b0, 0, 0, 0, 0, 1'b0},
		'{SET_UNIT, 1, -1, 3, 1'b0, 0, 0, 0, 0, 1'b0},
		'{SET_UNIT, 12345, -6789, -32768, 1'b0, 0, 0, 0, 0, 1'b0},
		// mecanum rows with input clamp, both dead bands and rescaling
		'{SET_MECANUM, 5000, 0, 0, 1'b0, 0, 0, 0, 0, 1'b0},
		'{SET_MECANUM, -5000, 0, 0, 1'b0, 0, 0, 0, 0, 1'b0},
		'{SET_MECANUM, 99, -99, 99, 1'b0, 0, 0, 0, 0, 1'b0},
		'{SET_MECANUM, 100, -100, 100, 1'b0, 0, 0, 0, 0, 1'b0},
		'{SET_MECANUM, 800, 800, 800, 1'b0, 0, 0, 0, 0, 1'b0},
		'{SET_MECANUM, 300, 280, 0, 1'b0, 0, 0, 0, 0, 1'b0},
		'{SET_MECANUM, -32768, 32767, -32768, 1'b0, 0, 0, 0, 0, 1'b0},
		// zero output limit: any motion collapses to zero with the flag set
		'{SET_ZERO_MAX_OUT, 1000, 0, 0, 1'b1, 0, 0, 0, 0, 1'b1},
		'{SET_ZERO_MAX_OUT, 0, 0, 0, 1'b1, 0, 0, 0, 0, 1'b0},
		'{SET_ZERO_MAX_OUT, 0, 0, -1, 1'b1, 0, 0, 0, 0, 1'b1},
		// input band above input limit: everything is zeroed
		'{SET_CROSSED_IN, 32767, -32768, 150, 1'b1, 0, 0, 0, 0, 1'b0},
		'{SET_CROSSED_IN, -1, 1, 0, 1'b1, 0, 0, 0, 0, 1'b0}
	};

	function automatic logic [CFG_DATA_W-1:0] pack_row(int cx, int cy, int cyaw);
		return {cyaw[COEF_W-1:0], cy[COEF_W-1:0], cx[COEF_W-1:0]};
	endfunction

	// Clamp to the input limit, then apply the input dead band
	function automatic longint guard_component(speed_t v);
		longint c;
		c = longint'(v);
		if (c > longint'(in_limit)) c = longint'(in_limit);
		if (c < -longint'(in_limit)) c = -longint'(in_limit);
		if ((c < 0 ? -c : c) < longint'(in_band)) c = 0;
		return c;
	endfunction

	// Wheel speeds for one body velocity command under the shadow registers
	function automatic wheel_set_t predict_wheels(speed_t vx, speed_t vy, speed_t vyaw);
		longint body [3];
		longint spd [MAX_WHEELS];
		longint acc, mag, peak;
		int w, e;
		wheel_set_t r;
		body[0] = guard_component(vx);
		body[1] = guard_component(vy);
		body[2] = guard_component(vyaw);
		r = '0;
		peak = 0;
		for (w = 0; w < MAX_WHEELS; w++) spd[w] = 0;
		// dot product, Q2.13 back to integer, round half away from zero
		for (w = 0; w < WHEELS; w++) begin
			acc = 0;
			for (e = 0; e < 3; e++)
				acc += longint'($signed(coef_row[w][COEF_W*e +: COEF_W])) * body[e];
			mag = acc < 0 ? -acc : acc;
			mag = (mag + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
			spd[w] = acc < 0 ? -mag : mag;
			if (spd[w] > 32767) spd[w] = 32767;
			if (spd[w] < -32768) spd[w] = -32768;
			mag = spd[w] < 0 ? -spd[w] : spd[w];
			if (mag > peak) peak = mag;
		end
		// proportional rescale when the largest wheel is over the limit
		r.rescaled = peak > longint'(out_limit);
		if (r.rescaled) begin
			for (w = 0; w < WHEELS; w++) begin
				mag = spd[w] < 0 ? -spd[w] : spd[w];
				mag = (mag * longint'(out_limit) + peak / 2) / peak;
				spd[w] = spd[w] < 0 ? -mag : mag;
			end
		end
		for (w = 0; w < WHEELS; w++) begin
			mag = spd[w] < 0 ? -spd[w] : spd[w];
			if (mag < longint'(out_band)) spd[w] = 0;
		end
		for (w = 0; w < MAX_WHEELS; w++) r.speed[w] = SPEED_W'(spd[w]);
		return r;
	endfunction

	// Velocity mix: extremes, values around the clamp and band edges, small and wide
	function automatic speed_t pick_velocity();
		int sel;
		int v;
		sel = $urandom_range(99);
		if (sel < 8) begin
			case ($urandom_range(4))
				0: v = -32768;
				1: v = 32767;
				2: v = 0;
				3: v = -1;
				default: v = 1;
			endcase
		end else if (sel < 20) begin
			v = (sel < 14) ? int'(in_limit) : int'(in_band);
			v = v + int'($urandom_range(2)) - 1;
			if ($urandom_range(1)) v = -v;
		end else if (sel < 55) begin
			v = int'($urandom_range(4000)) - 2000;
		end else begin
			v = int'($urandom);
		end
		return SPEED_W'(v);
	endfunction

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		case (idx)
			REG_WHEEL0_COEF: coef_row[0] = value;
			REG_WHEEL1_COEF: coef_row[1] = value;
			REG_WHEEL2_COEF: coef_row[2] = value;
			REG_WHEEL3_COEF: coef_row[3] = value;
			REG_MAX_INPUT:   in_limit = value[LIM_W-1:0];
			REG_MIN_INPUT:   in_band = value[LIM_W-1:0];
			REG_MAX_OUTPUT:  out_limit = value[LIM_W-1:0];
			REG_MIN_OUTPUT:  out_band = value[LIM_W-1:0];
			default: ;
		endcase
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(setting_e s);
		case (s)
			SET_UNIT: begin
				write_register(REG_WHEEL0_COEF, pack_row(8192, 0, 0));
				write_register(REG_WHEEL1_COEF, pack_row(0, 8192, 0));
				write_register(REG_WHEEL2_COEF, pack_row(0, 0, 8192));
				write_register(REG_WHEEL3_COEF, pack_row(-8192, 4096, 0));
				write_register(REG_MAX_INPUT, 48'd32767);
				write_register(REG_MIN_INPUT, 48'd0);
				write_register(REG_MAX_OUTPUT, 48'd32767);
				write_register(REG_MIN_OUTPUT, 48'd0);
			end
			SET_MECANUM: begin
				write_register(REG_WHEEL0_COEF, pack_row(8192, -8192, -8192));
				write_register(REG_WHEEL1_COEF, pack_row(8192, 8192, 8192));
				write_register(REG_WHEEL2_COEF, pack_row(8192, 8192, -8192));
				write_register(REG_WHEEL3_COEF, pack_row(8192, -8192, 8192));
				write_register(REG_MAX_INPUT, 48'd1000);
				write_register(REG_MIN_INPUT, 48'd100);
				write_register(REG_MAX_OUTPUT, 48'd1500);
				write_register(REG_MIN_OUTPUT, 48'd50);
			end
			SET_ZERO_MAX_OUT: begin
				write_register(REG_MAX_INPUT, 48'd32767);
				write_register(REG_MIN_INPUT, 48'd0);
				write_register(REG_MAX_OUTPUT, 48'd0);
				write_register(REG_MIN_OUTPUT, 48'd0);
			end
			SET_CROSSED_IN: begin
				write_register(REG_MAX_INPUT, 48'd0);
				write_register(REG_MIN_INPUT, 48'd32767);
				write_register(REG_MAX_OUTPUT, 48'd32767);
				write_register(REG_MIN_OUTPUT, 48'd32767);
				write_register(REG_UNMAPPED, '1);
			end
			default: ;
		endcase
	endtask

	// New random coefficients and limits; extremes and masked wide data show up too
	task automatic randomize_setup();
		int w, style, pick;
		logic [63:0] wide;
		logic [CFG_DATA_W-1:0] row;
		style = $urandom_range(3);
		for (w = 0; w < MAX_WHEELS; w++) begin
			wide = {$urandom, $urandom};
			case (style)
				0: row = pack_row($urandom_range(1) ? 8192 : -8192,
					$urandom_range(1) ? 8192 : -8192, $urandom_range(1) ? 8192 : -8192);
				1: row = wide[CFG_DATA_W-1:0];
				2: row = pack_row(int'($urandom_range(16384)) - 8192,
					int'($urandom_range(16384)) - 8192, int'($urandom_range(16384)) - 8192);
				default: row = pack_row(int'($urandom_range(8192)) - 4096,
					int'($urandom_range(1024)) - 512, int'($urandom_range(32767)) - 16384);
			endcase
			write_register(REG_WHEEL0_COEF + CFG_IDX_W'(w), row);
		end

		wide = {$urandom, $urandom};
		pick = $urandom_range(9);
		write_register(REG_MAX_INPUT, pick < 5 ? 48'd32767 :
			pick == 5 ? CFG_DATA_W'($urandom_range(1, 500)) :
			pick < 9 ? CFG_DATA_W'($urandom_range(1, 32767)) : wide[CFG_DATA_W-1:0]);

		wide = {$urandom, $urandom};
		pick = $urandom_range(9);
		write_register(REG_MIN_INPUT, pick < 6 ? 48'd0 :
			pick < 9 ? CFG_DATA_W'($urandom_range(3000)) : wide[CFG_DATA_W-1:0]);

		wide = {$urandom, $urandom};
		pick = $urandom_range(9);
		write_register(REG_MAX_OUTPUT, pick < 4 ? 48'd32767 : pick == 4 ? 48'd1 :
			pick < 9 ? CFG_DATA_W'($urandom_range(1, 32767)) : wide[CFG_DATA_W-1:0]);

		pick = $urandom_range(9);
		write_register(REG_MIN_OUTPUT, pick < 6 ? 48'd0 :
			pick < 9 ? CFG_DATA_W'($urandom_range(2000)) : 48'd32767);
	endtask

	// Hold one request until accepted, then queue what it should produce
	task automatic issue_command(speed_t vx, speed_t vy, speed_t vyaw, logic typed,
		wheel_set_t typed_want);
		cmd_bus.valid    <= 1'b1;
		cmd_bus.vel_x    <= vx;
		cmd_bus.vel_y    <= vy;
		cmd_bus.yaw_rate <= vyaw;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
		pending_wheels.push_back(typed ? typed_want : predict_wheels(vx, vy, vyaw));
	endtask

	// Random gap between requests; the idle bus carries junk
	task automatic sender_pause();
		int gap;
		gap = 0;
		while (gap < 64 && $urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			cmd_bus.valid    <= 1'b0;
			cmd_bus.vel_x    <= SPEED_W'($urandom);
			cmd_bus.vel_y    <= SPEED_W'($urandom);
			cmd_bus.yaw_rate <= SPEED_W'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and let the pipeline empty out
	task automatic wait_idle();
		cmd_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending_wheels.size() != 0) @(posedge clk);
		repeat (STAGES + 4) @(posedge clk);
	endtask

	// Receiver back-pressure
	always @(posedge clk) begin
		wheel_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : wheel_check
		wheel_set_t seen;
		wheel_set_t want;
		int w;
		if (arst_n && wheel_bus.valid && wheel_bus.ready) begin
			seen.speed[0] = wheel_bus.wheel0_speed;
			seen.speed[1] = wheel_bus.wheel1_speed;
			seen.speed[2] = wheel_bus.wheel2_speed;
			seen.speed[3] = wheel_bus.wheel3_speed;
			seen.rescaled = wheel_bus.was_rescaled;
			if (pending_wheels.size() == 0) begin
				$error("wheel result with no request outstanding");
				bad_results++;
			end else begin
				want = pending_wheels.pop_front();
				for (w = 0; w < MAX_WHEELS; w++) begin
					if (seen.speed[w] !== want.speed[w]) begin
						$error("wheel%0d_speed: expected %0d, got %0d", w,
							$signed(want.speed[w]), $signed(seen.speed[w]));
						bad_results++;
					end
				end
				if (seen.rescaled !== want.rescaled) begin
					$error("was_rescaled: expected %0b, got %0b", want.rescaled, seen.rescaled);
					bad_results++;
				end
			end
		end
	end

	initial begin : stimulus
		int r, blk, i;
		setting_e active;
		wheel_set_t typed_want;
		arst_n             <= 1'b0;
		cmd_bus.valid      <= 1'b0;
		cmd_bus.vel_x      <= '0;
		cmd_bus.vel_y      <= '0;
		cmd_bus.yaw_rate   <= '0;
		cfg_bus.valid      <= 1'b0;
		cfg_bus.index      <= '0;
		cfg_bus.data       <= '0;
		for (i = 0; i < MAX_WHEELS; i++) coef_row[i] = '0;
		in_limit  = 15'd32767;
		in_band   = 15'd0;
		out_limit = 15'd32767;
		out_band  = 15'd0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, no idling
		active = SET_RESET;
		for (r = 0; r < TABLE_ROWS; r++) begin
			if (stim_table[r].setting != active) begin
				active = stim_table[r].setting;
				apply_setting(active);
			end
			typed_want.speed[0] = stim_table[r].w0;
			typed_want.speed[1] = stim_table[r].w1;
			typed_want.speed[2] = stim_table[r].w2;
			typed_want.speed[3] = stim_table[r].w3;
			typed_want.rescaled = stim_table[r].rescaled;
			issue_command(stim_table[r].vx, stim_table[r].vy, stim_table[r].vyaw,
				stim_table[r].typed, typed_want);
			if (r == TABLE_ROWS - 1 || stim_table[r + 1].setting != active)
				wait_idle();
			else
				sender_pause();
		end

		// Random blocks, each with fresh registers and its own idling pattern
		for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			case (blk % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			randomize_setup();
			for (i = 0; i < BLOCK_ITEMS; i++) begin
				issue_command(pick_velocity(), pick_velocity(), pick_velocity(), 1'b0, '0);
				// once, mid-block under receiver stalls, hold off until all results drain
				if (i == BLOCK_ITEMS - 1 || (blk == 2 && i == BLOCK_ITEMS / 2))
					wait_idle();
				else
					sender_pause();
			end
		end

		if (bad_results == 0 && pending_wheels.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin : watchdog
		#TIMEOUT_NS;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
